/* rtl/express_ring_route_select_unit_macros.svh */
// Assertion macros shared by the express ring route select RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef EXPRESS_RING_ROUTE_SELECT_UNIT_MACROS_SVH
`define EXPRESS_RING_ROUTE_SELECT_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset
`define ERRS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a valid flag is clear in the cycle after reset
`define ERRS_ASSERT_RESET(label, clk, rst, sig, msg) \
   label: assert property (@(posedge clk) rst |=> !(sig)) else $error(msg);

`endif

/* rtl/errs_pkg.sv */
// Shared types and constants for the express ring route select unit.
// No dependencies; imported by every module of the block.
package errs_pkg;

   localparam int unsigned MAX_SWITCHES      = 1024;
   localparam int unsigned MAX_CONCENTRATION = 64;

   localparam int unsigned NODE_W      = 16;
   localparam int unsigned RING_W      = 11;
   localparam int unsigned JUMP_W      = 10;
   localparam int unsigned CONC_W      = 7;
   localparam int unsigned SW_W        = 10;
   localparam int unsigned PORT_W      = 7;
   localparam int unsigned REM_W       = 6;
   localparam int unsigned DIST_W      = 18;
   localparam int unsigned CSR_ADDR_W  = 4;
   localparam int unsigned CSR_DATA_W  = 32;

   // Reciprocal scaling: floor(2^RECIP_SHIFT / c), exact within one after the multiply
   localparam int unsigned RECIP_SHIFT = 22;
   localparam int unsigned RECIP_W     = 23;
   localparam int unsigned PROD_W      = NODE_W + RECIP_W;
   localparam int unsigned RECIP_NUM   = 1 << RECIP_SHIFT;

   localparam logic [PORT_W-1:0] PORT_UP         = PORT_W'(0);
   localparam logic [PORT_W-1:0] PORT_DOWN       = PORT_W'(1);
   localparam logic [PORT_W-1:0] PORT_JUMP_UP    = PORT_W'(2);
   localparam logic [PORT_W-1:0] PORT_JUMP_DOWN  = PORT_W'(3);
   localparam logic [PORT_W-1:0] PORT_EJECT_BASE = PORT_W'(4);

   localparam logic [RING_W-1:0] RING_RESET = RING_W'(8);
   localparam logic [JUMP_W-1:0] JUMP_RESET = JUMP_W'(2);
   localparam logic [CONC_W-1:0] CONC_RESET = CONC_W'(1);
   localparam logic [SW_W-1:0]   OWN_RESET  = SW_W'(0);

   typedef enum logic [1:0] {
      REG_RING_SWITCHES    = 2'd0,
      REG_JUMP_DISTANCE    = 2'd1,
      REG_NODES_PER_SWITCH = 2'd2,
      REG_OWN_SWITCH       = 2'd3
   } csr_reg_type;

   // Effective configuration after clamping
   typedef struct packed {
      logic [RING_W-1:0] ring_size;
      logic [JUMP_W-1:0] jump;
      logic [CONC_W-1:0] conc;
      logic [SW_W-1:0]   own;
   } cfg_type;

   // Destination switch and node remainder handed to the routing stages
   typedef struct packed {
      logic [NODE_W-1:0] dest_switch;
      logic [REM_W-1:0]  node_rem;
      logic              crossed;
   } quot_type;

   // Reciprocal table, entry k serves concentration k+1
   localparam logic [RECIP_W-1:0] RECIP_TABLE [MAX_CONCENTRATION] = '{
      RECIP_W'(RECIP_NUM / 1),  RECIP_W'(RECIP_NUM / 2),
      RECIP_W'(RECIP_NUM / 3),  RECIP_W'(RECIP_NUM / 4),
      RECIP_W'(RECIP_NUM / 5),  RECIP_W'(RECIP_NUM / 6),
      RECIP_W'(RECIP_NUM / 7),  RECIP_W'(RECIP_NUM / 8),
      RECIP_W'(RECIP_NUM / 9),  RECIP_W'(RECIP_NUM / 10),
      RECIP_W'(RECIP_NUM / 11), RECIP_W'(RECIP_NUM / 12),
      RECIP_W'(RECIP_NUM / 13), RECIP_W'(RECIP_NUM / 14),
      RECIP_W'(RECIP_NUM / 15), RECIP_W'(RECIP_NUM / 16),
      RECIP_W'(RECIP_NUM / 17), RECIP_W'(RECIP_NUM / 18),
      RECIP_W'(RECIP_NUM / 19), RECIP_W'(RECIP_NUM / 20),
      RECIP_W'(RECIP_NUM / 21), RECIP_W'(RECIP_NUM / 22),
      RECIP_W'(RECIP_NUM / 23), RECIP_W'(RECIP_NUM / 24),
      RECIP_W'(RECIP_NUM / 25), RECIP_W'(RECIP_NUM / 26),
      RECIP_W'(RECIP_NUM / 27), RECIP_W'(RECIP_NUM / 28),
      RECIP_W'(RECIP_NUM / 29), RECIP_W'(RECIP_NUM / 30),
      RECIP_W'(RECIP_NUM / 31), RECIP_W'(RECIP_NUM / 32),
      RECIP_W'(RECIP_NUM / 33), RECIP_W'(RECIP_NUM / 34),
      RECIP_W'(RECIP_NUM / 35), RECIP_W'(RECIP_NUM / 36),
      RECIP_W'(RECIP_NUM / 37), RECIP_W'(RECIP_NUM / 38),
      RECIP_W'(RECIP_NUM / 39), RECIP_W'(RECIP_NUM / 40),
      RECIP_W'(RECIP_NUM / 41), RECIP_W'(RECIP_NUM / 42),
      RECIP_W'(RECIP_NUM / 43), RECIP_W'(RECIP_NUM / 44),
      RECIP_W'(RECIP_NUM / 45), RECIP_W'(RECIP_NUM / 46),
      RECIP_W'(RECIP_NUM / 47), RECIP_W'(RECIP_NUM / 48),
      RECIP_W'(RECIP_NUM / 49), RECIP_W'(RECIP_NUM / 50),
      RECIP_W'(RECIP_NUM / 51), RECIP_W'(RECIP_NUM / 52),
      RECIP_W'(RECIP_NUM / 53), RECIP_W'(RECIP_NUM / 54),
      RECIP_W'(RECIP_NUM / 55), RECIP_W'(RECIP_NUM / 56),
      RECIP_W'(RECIP_NUM / 57), RECIP_W'(RECIP_NUM / 58),
      RECIP_W'(RECIP_NUM / 59), RECIP_W'(RECIP_NUM / 60),
      RECIP_W'(RECIP_NUM / 61), RECIP_W'(RECIP_NUM / 62),
      RECIP_W'(RECIP_NUM / 63), RECIP_W'(RECIP_NUM / 64)
   };

endpackage

/* rtl/errs_csr.sv */
// Configuration register file for the express ring route select unit.
// Depends on errs_pkg; presents clamped settings to the datapath.
module errs_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [errs_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [errs_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [errs_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready,
   output errs_pkg::cfg_type                  cfg
);
   import errs_pkg::*;

   logic [RING_W-1:0] ring_ff;
   logic [JUMP_W-1:0] jump_ff;
   logic [CONC_W-1:0] conc_ff;
   logic [SW_W-1:0]   own_ff;
   logic              wr_en;
   csr_reg_type       reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = csr_reg_type'(csr_paddr[3:2]);

   // Write registers on the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_ff <= RING_RESET;
         jump_ff <= JUMP_RESET;
         conc_ff <= CONC_RESET;
         own_ff  <= OWN_RESET;
      end else if (wr_en) begin
         case (reg_sel)
            REG_RING_SWITCHES:    ring_ff <= csr_pwdata[RING_W-1:0];
            REG_JUMP_DISTANCE:    jump_ff <= csr_pwdata[JUMP_W-1:0];
            REG_NODES_PER_SWITCH: conc_ff <= csr_pwdata[CONC_W-1:0];
            REG_OWN_SWITCH:       own_ff  <= csr_pwdata[SW_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back raw register values
   always_comb begin
      case (reg_sel)
         REG_RING_SWITCHES:    csr_prdata = CSR_DATA_W'(ring_ff);
         REG_JUMP_DISTANCE:    csr_prdata = CSR_DATA_W'(jump_ff);
         REG_NODES_PER_SWITCH: csr_prdata = CSR_DATA_W'(conc_ff);
         REG_OWN_SWITCH:       csr_prdata = CSR_DATA_W'(own_ff);
         default:              csr_prdata = '0;
      endcase
   end

   // Clamp concentration to 1..max and ring size to the max
   always_comb begin
      cfg.jump = jump_ff;
      cfg.own  = own_ff;
      if (conc_ff == '0) begin
         cfg.conc = CONC_W'(1);
      end else if (conc_ff > CONC_W'(MAX_CONCENTRATION)) begin
         cfg.conc = CONC_W'(MAX_CONCENTRATION);
      end else begin
         cfg.conc = conc_ff;
      end
      if (ring_ff > RING_W'(MAX_SWITCHES)) begin
         cfg.ring_size = RING_W'(MAX_SWITCHES);
      end else begin
         cfg.ring_size = ring_ff;
      end
   end

endmodule

/* rtl/errs_div.sv */
// Three-stage divider: destination node over concentration by reciprocal multiply.
// Depends on errs_pkg and the shared assertion macros.
`include "express_ring_route_select_unit_macros.svh"

module errs_div (
   input  logic                          clock,
   input  logic                          reset,
   input  errs_pkg::cfg_type             cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [errs_pkg::NODE_W-1:0]   in_node,
   input  logic                          in_crossed,
   output logic                          out_valid,
   input  logic                          out_ready,
   output errs_pkg::quot_type            out_quot
);
   import errs_pkg::*;

   // Stage A: product with reciprocal
   logic                a_valid_ff;
   logic [PROD_W-1:0]   a_prod_ff, a_prod_in;
   logic [NODE_W-1:0]   a_node_ff;
   logic                a_crossed_ff;
   // Stage B: estimated quotient and remainder
   logic                b_valid_ff;
   logic [NODE_W-1:0]   b_quot_ff, b_quot_in;
   logic [CONC_W-1:0]   b_rem_ff, b_rem_in;
   logic                b_crossed_ff;
   // Stage C: corrected quotient and remainder
   logic                c_valid_ff;
   logic [NODE_W-1:0]   c_dest_ff, c_dest_in;
   logic [REM_W-1:0]    c_rem_ff, c_rem_in;
   logic                c_crossed_ff;

   logic                a_adv, b_adv, c_adv;
   logic [CONC_W-1:0]   conc_m1;
   logic [RECIP_W-1:0]  recip;
   logic [NODE_W+CONC_W-1:0] quot_conc;
   logic [NODE_W-1:0]   rem_full;
   logic [CONC_W-1:0]   rem_fix;

   // Advance a stage when it is empty or its successor moves
   assign c_adv    = !c_valid_ff | out_ready;
   assign b_adv    = !b_valid_ff | c_adv;
   assign a_adv    = !a_valid_ff | b_adv;
   assign in_ready = a_adv;

   // Look up reciprocal and multiply
   assign conc_m1   = cfg.conc - CONC_W'(1);
   assign recip     = RECIP_TABLE[conc_m1[REM_W-1:0]];
   assign a_prod_in = PROD_W'(in_node) * PROD_W'(recip);

   // Estimate is floor or one below; form the remainder
   assign b_quot_in = a_prod_ff[RECIP_SHIFT +: NODE_W];
   assign quot_conc = (NODE_W+CONC_W)'(b_quot_in) * (NODE_W+CONC_W)'(cfg.conc);
   assign rem_full  = a_node_ff - quot_conc[NODE_W-1:0];
   assign b_rem_in  = rem_full[CONC_W-1:0];

   // Correct by one step when the remainder reaches the divisor
   assign rem_fix = b_rem_ff - cfg.conc;
   always_comb begin
      if (b_rem_ff >= cfg.conc) begin
         c_dest_in = b_quot_ff + NODE_W'(1);
         c_rem_in  = rem_fix[REM_W-1:0];
      end else begin
         c_dest_in = b_quot_ff;
         c_rem_in  = b_rem_ff[REM_W-1:0];
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (a_adv) a_valid_ff <= in_valid;
         if (b_adv) b_valid_ff <= a_valid_ff;
         if (c_adv) c_valid_ff <= b_valid_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (a_adv) begin
         a_prod_ff    <= a_prod_in;
         a_node_ff    <= in_node;
         a_crossed_ff <= in_crossed;
      end
      if (b_adv) begin
         b_quot_ff    <= b_quot_in;
         b_rem_ff     <= b_rem_in;
         b_crossed_ff <= a_crossed_ff;
      end
      if (c_adv) begin
         c_dest_ff    <= c_dest_in;
         c_rem_ff     <= c_rem_in;
         c_crossed_ff <= b_crossed_ff;
      end
   end

   assign out_valid            = c_valid_ff;
   assign out_quot.dest_switch = c_dest_ff;
   assign out_quot.node_rem    = c_rem_ff;
   assign out_quot.crossed     = c_crossed_ff;

   `ERRS_ASSERT(a_rem_below_conc, clock, reset, c_valid_ff |-> (c_rem_ff < cfg.conc[REM_W-1:0] || cfg.conc[REM_W]), "remainder not below concentration")
   `ERRS_ASSERT(a_stall_holds, clock, reset, c_valid_ff && !out_ready |=> c_valid_ff && $stable(c_dest_ff), "stalled quotient changed")
   `ERRS_ASSERT_RESET(a_reset_empty, clock, reset, a_valid_ff || b_valid_ff || c_valid_ff, "divider not empty after reset")

endmodule

/* rtl/errs_route.sv */
// Two-stage route decision: ring distances, then port and crossed-bit choice.
// Depends on errs_pkg and the shared assertion macros.
`include "express_ring_route_select_unit_macros.svh"

module errs_route (
   input  logic                          clock,
   input  logic                          reset,
   input  errs_pkg::cfg_type             cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  errs_pkg::quot_type            in_quot,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [errs_pkg::PORT_W-1:0]   out_port,
   output logic                          out_vc,
   output logic                          out_crossed,
   output logic                          out_bad
);
   import errs_pkg::*;

   // Stage D: distances and flags
   logic                      d_valid_ff;
   logic signed [DIST_W-1:0]  d_up_ff, d_up_in;
   logic signed [DIST_W-1:0]  d_down_ff, d_down_in;
   logic                      d_local_ff, d_bad_ff, d_crossed_ff;
   logic [REM_W-1:0]          d_rem_ff;
   // Stage E: result register
   logic                      e_valid_ff;
   logic [PORT_W-1:0]         e_port_ff, e_port_in;
   logic                      e_vc_ff, e_vc_in;
   logic                      e_crossed_ff, e_crossed_in;
   logic                      e_bad_ff;

   logic                      d_adv, e_adv;
   logic signed [DIST_W-1:0]  sw_s, sw_d, sw_r, sw_j;
   logic [RING_W-1:0]         own_plus_jump, own_plus_one, own_ext, jump_ext;
   logic [PORT_W-1:0]         route_port;
   logic                      wraps;

   assign e_adv    = !e_valid_ff | out_ready;
   assign d_adv    = !d_valid_ff | e_adv;
   assign in_ready = d_adv;

   // Measure up and down ring distances as signed values
   assign sw_s = DIST_W'(cfg.own);
   assign sw_d = DIST_W'(in_quot.dest_switch);
   assign sw_r = DIST_W'(cfg.ring_size);
   assign sw_j = DIST_W'(cfg.jump);
   assign d_up_in   = (sw_d > sw_s) ? sw_d - sw_s : sw_r - sw_s + sw_d;
   assign d_down_in = (sw_s > sw_d) ? sw_s - sw_d : sw_s + sw_r - sw_d;

   // Pick the link: exact jump or neighbour first, then the shorter way
   always_comb begin
      if (d_up_ff == sw_j) begin
         route_port = PORT_JUMP_UP;
      end else if (d_up_ff == DIST_W'(1)) begin
         route_port = PORT_UP;
      end else if (d_down_ff == sw_j) begin
         route_port = PORT_JUMP_DOWN;
      end else if (d_down_ff == DIST_W'(1)) begin
         route_port = PORT_DOWN;
      end else if (d_up_ff <= d_down_ff) begin
         route_port = (d_up_ff > sw_j) ? PORT_JUMP_UP : PORT_UP;
      end else begin
         route_port = (d_down_ff > sw_j) ? PORT_JUMP_DOWN : PORT_DOWN;
      end
   end

   // Flag links that wrap past switch zero
   assign own_ext       = RING_W'(cfg.own);
   assign jump_ext      = RING_W'(cfg.jump);
   assign own_plus_jump = own_ext + jump_ext;
   assign own_plus_one  = own_ext + RING_W'(1);
   always_comb begin
      case (route_port)
         PORT_JUMP_UP:   wraps = own_plus_jump >= cfg.ring_size;
         PORT_UP:        wraps = own_plus_one == cfg.ring_size;
         PORT_JUMP_DOWN: wraps = cfg.own < cfg.jump;
         default:        wraps = cfg.own == '0;
      endcase
   end

   // Eject locally or take the ring link
   always_comb begin
      if (d_local_ff) begin
         e_port_in    = PORT_EJECT_BASE + PORT_W'(d_rem_ff);
         e_vc_in      = 1'b0;
         e_crossed_in = d_crossed_ff;
      end else begin
         e_port_in    = route_port;
         e_crossed_in = d_crossed_ff | wraps;
         e_vc_in      = e_crossed_in;
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         if (d_adv) d_valid_ff <= in_valid;
         if (e_adv) e_valid_ff <= d_valid_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (d_adv) begin
         d_up_ff      <= d_up_in;
         d_down_ff    <= d_down_in;
         d_local_ff   <= in_quot.dest_switch == NODE_W'(cfg.own);
         d_bad_ff     <= in_quot.dest_switch >= NODE_W'(cfg.ring_size);
         d_rem_ff     <= in_quot.node_rem;
         d_crossed_ff <= in_quot.crossed;
      end
      if (e_adv) begin
         e_port_ff    <= e_port_in;
         e_vc_ff      <= e_vc_in;
         e_crossed_ff <= e_crossed_in;
         e_bad_ff     <= d_bad_ff;
      end
   end

   assign out_valid   = e_valid_ff;
   assign out_port    = e_port_ff;
   assign out_vc      = e_vc_ff;
   assign out_crossed = e_crossed_ff;
   assign out_bad     = e_bad_ff;

   `ERRS_ASSERT(a_eject_vc_zero, clock, reset, e_valid_ff && e_port_ff >= PORT_EJECT_BASE |-> !e_vc_ff, "eject beat on nonzero channel")
   `ERRS_ASSERT(a_ring_vc_match, clock, reset, e_valid_ff && e_port_ff < PORT_EJECT_BASE |-> e_vc_ff == e_crossed_ff, "channel differs from crossed bit")
   `ERRS_ASSERT_RESET(a_reset_empty, clock, reset, d_valid_ff || e_valid_ff, "route stages not empty after reset")

endmodule

/* rtl/express_ring_route_select_unit.sv */
// Express ring route select: one header beat in, one port decision out, every cycle.
// Each req beat passes in order through reciprocal multiply, remainder
// estimate, quotient correction, ring distances, port choice into the output register.
// Throughput is one beat per clock; each pipeline stage holds under rsp backpressure
// and fills bubbles.
// Program the registers only while no beat is in flight.
// Depends on errs_pkg, errs_csr, errs_div, errs_route.
module express_ring_route_select_unit (
   input  logic                               clock,
   input  logic                               reset,
   // Header beat
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [15:0]                        req_tdata,   // [15:0] target_node
   input  logic                               req_tuser,   // [0] crossed_in
   // Route decision beat
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [15:0]                        rsp_tdata,   // [6:0] out_port,
                                                           // [7] virtual_channel,
                                                           // [8] crossed_out, rest 0
   output logic                               rsp_tuser,   // [0] bad_dest
   // Register port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [errs_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [errs_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [errs_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import errs_pkg::*;

   cfg_type            cfg;
   quot_type           quot;
   logic               quot_valid, quot_ready;
   logic [PORT_W-1:0]  port;
   logic               vc, crossed;

   errs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   errs_div u_div (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_node    (req_tdata[NODE_W-1:0]),
      .in_crossed (req_tuser),
      .out_valid  (quot_valid),
      .out_ready  (quot_ready),
      .out_quot   (quot)
   );

   errs_route u_route (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .in_valid    (quot_valid),
      .in_ready    (quot_ready),
      .in_quot     (quot),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_port    (port),
      .out_vc      (vc),
      .out_crossed (crossed),
      .out_bad     (rsp_tuser)
   );

   // Pack the decision beat
   assign rsp_tdata = {7'b0, crossed, vc, port};

endmodule
